[rtl/core/rse_pkg.sv]
// Shared types, codes and helpers for the RPN stack evaluator.
package rse_pkg;

   localparam int DATA_W              = 32;
   localparam int OP_W                = 3;
   localparam int DEPTH_W             = 5;
   localparam int STATUS_W            = 2;
   localparam int STACK_DEPTH_DEFAULT = 16;

   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
   localparam logic [OP_W-1:0] OP_MOD  = 3'd5;
   localparam logic [OP_W-1:0] OP_ABS  = 3'd6;
   localparam logic [OP_W-1:0] OP_DUP  = 3'd7;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIVZ  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic [DEPTH_W-1:0]       depth;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   // two's complement magnitude, wraps for the most negative value
   function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
      mag = x[DATA_W-1] ? (DATA_W'(0) - x) : x;
   endfunction

endpackage

[rtl/core/rse_stream_if.sv]
// Valid/ready stream interface with a typed payload.
interface rse_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/rse_divider.sv]
// Signed restoring divider, one quotient bit per cycle.
module rse_divider import rse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient,
   output logic [DATA_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic              busy_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] dvsr_ff;
   logic              qneg_ff;
   logic              rneg_ff;

   logic [DATA_W:0] rem_shift;
   logic [DATA_W:0] diff;
   logic            fits;

   assign rem_shift = {rem_ff, quo_ff[DATA_W-1]};
   assign diff      = rem_shift - {1'b0, dvsr_ff};
   assign fits      = !diff[DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CNT_W'(DATA_W);
      end else if (busy_ff && count_ff != '0) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= mag(dividend);
         dvsr_ff <= mag(divisor);
         qneg_ff <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
         rneg_ff <= dividend[DATA_W-1];
      end else if (busy_ff && count_ff != '0) begin
         rem_ff <= fits ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
         quo_ff <= {quo_ff[DATA_W-2:0], fits};
      end
   end

   assign done      = busy_ff && (count_ff == '0);
   assign quotient  = qneg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
   assign remainder = rneg_ff ? (DATA_W'(0) - rem_ff) : rem_ff;

endmodule

[rtl/core/rpn_stack_evaluator_core.sv]
// Top level of the RPN stack evaluator: stack memory, control and result register.
//
// Reverse Polish integer evaluator. Each request transfer carries one operation
// (push, add, sub, mul, div, mod, abs, dup) and yields exactly one response
// transfer with the new top of stack, the depth and a status code. The stack
// lives in a STACK_DEPTH x 32 synchronous RAM; a copy of the top entry is held
// in a register, so push, dup, abs and every error case finish in the cycle the
// request is taken. Add, sub and mul need the second operand from the registered
// RAM read and finish in the EXEC state once the response register is free. Div
// and mod run on a bit-serial divider: RAM read, divider load, one iteration per
// quotient bit, write-back. A new request is taken as soon as the previous one
// is finished and the response register is empty or being drained. The stack
// RAM is not cleared after reset; entries above the top are never read.
module rpn_stack_evaluator_core import rse_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   rse_stream_if.sink   req_chan,
   rse_stream_if.source rsp_chan
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   // state
   logic [1:0]        state_ff, state_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_in;
   logic              rsp_load;

   // stack RAM
   logic [DATA_W-1:0] stack_mem_ff [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata;

   // datapath
   logic                req_fire, out_free, finish;
   logic [DATA_W-1:0]   prod_w;
   logic [DATA_W-1:0]   alu_res, div_res, pop_res;
   logic                div_start, div_done;
   logic [DATA_W-1:0]   div_quo, div_rem;
   logic [OP_W-1:0]     req_op;
   logic [DATA_W-1:0]   req_value;
   logic [DATA_W-1:0]   tos_mag;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_op         = req_chan.payload.op;
   assign req_value      = req_chan.payload.value;
   assign tos_mag        = mag(tos_ff);

   // a is the RAM read (entry sp-2), b is the cached top; low word only
   assign prod_w = rd_data_ff * tos_ff;

   always_comb begin
      case (op_ff)
         OP_ADD:  alu_res = rd_data_ff + tos_ff;
         OP_SUB:  alu_res = rd_data_ff - tos_ff;
         default: alu_res = prod_w;
      endcase
   end

   assign div_res = (op_ff == OP_MOD) ? div_rem : div_quo;
   assign pop_res = (state_ff == ST_DIV) ? div_res : alu_res;

   rse_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rd_data_ff),
      .divisor   (tos_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      tos_in    = tos_ff;
      op_in     = op_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(sp_ff);
      mem_wdata = req_value;
      mem_re    = 1'b0;
      mem_raddr = AW'(sp_ff - SPW'(2));
      div_start = 1'b0;
      finish    = 1'b0;
      rsp_load  = 1'b0;
      rsp_in.status    = STATUS_OK;
      rsp_in.depth     = DEPTH_W'(sp_ff);
      rsp_in.top_value = (sp_ff == '0) ? '0 : tos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_op;
               rsp_load = 1'b1;
               case (req_op)
                  OP_PUSH: begin
                     if (sp_ff == SP_FULL) begin
                        rsp_in.status = STATUS_OVER;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = req_value;
                        tos_in    = req_value;
                        sp_in     = sp_ff + SPW'(1);
                        rsp_in.depth     = DEPTH_W'(sp_ff + SPW'(1));
                        rsp_in.top_value = req_value;
                     end
                  end
                  OP_DUP: begin
                     if (sp_ff == '0) begin
                        rsp_in.status = STATUS_UNDER;
                     end else if (sp_ff == SP_FULL) begin
                        rsp_in.status = STATUS_OVER;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = tos_ff;
                        sp_in     = sp_ff + SPW'(1);
                        rsp_in.depth = DEPTH_W'(sp_ff + SPW'(1));
                     end
                  end
                  OP_ABS: begin
                     if (sp_ff == '0) begin
                        rsp_in.status = STATUS_UNDER;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(sp_ff - SPW'(1));
                        mem_wdata = tos_mag;
                        tos_in    = tos_mag;
                        rsp_in.top_value = tos_mag;
                     end
                  end
                  default: begin
                     // binary ops: fetch a, result comes later
                     if (sp_ff < SPW'(2)) begin
                        rsp_in.status = STATUS_UNDER;
                     end else if ((req_op inside {OP_DIV, OP_MOD}) && tos_ff == '0) begin
                        rsp_in.status = STATUS_DIVZ;
                     end else begin
                        rsp_load = 1'b0;
                        mem_re   = 1'b1;
                        state_in = ST_EXEC;
                     end
                  end
               endcase
            end
         end
         ST_EXEC: begin
            if (op_ff inside {OP_DIV, OP_MOD}) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (out_free) begin
               finish = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done && out_free) begin
               finish = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // pop two, push result at sp-2
      if (finish) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(sp_ff - SPW'(2));
         mem_wdata = pop_res;
         tos_in    = pop_res;
         sp_in     = sp_ff - SPW'(1);
         state_in  = ST_IDLE;
         rsp_load  = 1'b1;
         rsp_in.status    = STATUS_OK;
         rsp_in.depth     = DEPTH_W'(sp_ff - SPW'(1));
         rsp_in.top_value = pop_res;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      op_ff  <= op_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // stack pointer never passes the RAM size
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_FULL)
      else $error("stack pointer beyond depth");

   // a response is only loaded when the output register can take it
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("response overwritten before transfer");

   // binary op in flight always has two operands
   a_exec_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (sp_ff >= SPW'(2)))
      else $error("binary op started with fewer than two entries");

   // divider is never started with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (tos_ff != '0))
      else $error("divider started with zero divisor");

   // the stack pointer holds while a divide runs
   a_div_sp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !finish) |=> $stable(sp_ff))
      else $error("stack pointer moved during divide");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the RPN stack evaluator core: directed steps, then random programs.
`timescale 1ns / 100ps

module tb_top;
   import rse_pkg::*;

   localparam int STACK_DEPTH   = STACK_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 1510;
   localparam int HOLD_CYCLES   = 400;      // long output stall, fills the core
   localparam int SETTLE_CYCLES = 50;       // quiet time after the last response is back
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [DATA_W-1:0] MOST_NEG  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MOST_POS  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] FILL_WORD = 32'hA5A5_5A5A;

   // random program flavor: balanced, stack-growing, stack-shrinking
   typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_mode_type;

   // one row of the directed program; known_rsp is used when has_known is set
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
      logic [7:0]        reps;
      logic              has_known;
      rsp_type           known_rsp;
   } step_row_type;

   logic clock;
   logic reset;

   rse_stream_if #(.payload_type(req_type)) req_if ();
   rse_stream_if #(.payload_type(rsp_type)) rsp_if ();

   rpn_stack_evaluator_core #(.STACK_DEPTH(STACK_DEPTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow stack, advanced once per accepted operation
   logic [DATA_W-1:0] stack_words [STACK_DEPTH];
   int unsigned       stack_count;
   int unsigned       deepest_seen;

   rsp_type      expected_q [$];
   step_row_type directed_rows [26];

   int sender_idle_pct;
   int rsp_idle_pct;
   int hold_requested;
   int hold_served = 0;
   int hold_left = 0;
   int backpressure_cycles = 0;
   int mismatch_count = 0;
   int results_checked = 0;
   int cycle_count;
   int op_seen [8];
   int status_seen [4] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run-length guard; a hang anywhere ends here
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [DATA_W-1:0] wrap_abs(input logic [DATA_W-1:0] x);
      return x[DATA_W-1] ? -x : x;
   endfunction

   // Applies one operation to the shadow stack and returns the response it implies.
   // Errors leave the stack untouched; underflow is tested before divide by zero.
   function automatic rsp_type eval_op(input req_type item);
      logic [DATA_W-1:0]   a;
      logic [DATA_W-1:0]   b;
      logic [DATA_W-1:0]   res;
      logic [DATA_W-1:0]   quo;
      logic [DATA_W-1:0]   rem;
      logic [STATUS_W-1:0] st;
      rsp_type             out;
      st = STATUS_OK;
      case (item.op)
         OP_PUSH: begin
            if (stack_count >= STACK_DEPTH) begin
               st = STATUS_OVER;
            end else begin
               stack_words[stack_count] = item.value;
               stack_count++;
            end
         end
         OP_DUP: begin
            if (stack_count == 0) begin
               st = STATUS_UNDER;
            end else if (stack_count >= STACK_DEPTH) begin
               st = STATUS_OVER;
            end else begin
               stack_words[stack_count] = stack_words[stack_count-1];
               stack_count++;
            end
         end
         OP_ABS: begin
            if (stack_count == 0) st = STATUS_UNDER;
            else stack_words[stack_count-1] = wrap_abs(stack_words[stack_count-1]);
         end
         default: begin
            if (stack_count < 2) begin
               st = STATUS_UNDER;
            end else begin
               b = stack_words[stack_count-1];
               a = stack_words[stack_count-2];
               if ((item.op inside {OP_DIV, OP_MOD}) && b == '0) begin
                  st = STATUS_DIVZ;
               end else begin
                  // magnitudes keep most-neg / -1 well defined (wraps to most-neg)
                  quo = wrap_abs(a) / wrap_abs(b);
                  rem = wrap_abs(a) % wrap_abs(b);
                  case (item.op)
                     OP_ADD:  res = a + b;
                     OP_SUB:  res = a - b;
                     OP_MUL:  res = a * b;
                     OP_DIV:  res = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quo : quo;
                     default: res = a[DATA_W-1] ? -rem : rem;   // sign of dividend
                  endcase
                  stack_words[stack_count-2] = res;
                  stack_count--;
               end
            end
         end
      endcase
      if (stack_count > deepest_seen) deepest_seen = stack_count;
      out.top_value = (stack_count == 0) ? '0 : stack_words[stack_count-1];
      out.depth     = DEPTH_W'(stack_count);
      out.status    = st;
      return out;
   endfunction

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      $display("[%0t] %s mismatch on result %0d: expected %0h, got %0h",
               $time, field, results_checked, want, got);
      mismatch_count++;
   endtask

   // Offers one operation, optionally after a random gap with junk on the bus,
   // and records what it should produce once the core takes it.
   task automatic send_op(input req_type item, input logic use_known, input rsp_type known);
      rsp_type predicted;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= {OP_W'($urandom()), DATA_W'($urandom())};
         repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 3)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      predicted = eval_op(item);
      if (use_known) predicted = known;
      expected_q = {expected_q, predicted};
      op_seen[item.op]++;
   endtask

   // Sender goes quiet until every response is back, then lets the core settle.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: checks each transfer, then picks next cycle's ready.
   // A requested long hold is counted here so the sender keeps pushing into it.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result, top", '0, rsp_if.payload.top_value);
            end else begin
               want = expected_q.pop_front();
               status_seen[want.status]++;
               if (rsp_if.payload.top_value !== want.top_value)
                  report_mismatch("top_value", want.top_value, rsp_if.payload.top_value);
               if (rsp_if.payload.depth !== want.depth)
                  report_mismatch("depth", DATA_W'(want.depth), DATA_W'(rsp_if.payload.depth));
               if (rsp_if.payload.status !== want.status)
                  report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_if.payload.status));
            end
         end
         if (hold_served != hold_requested) begin
            hold_served = hold_requested;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            if (req_if.valid && !req_if.ready) backpressure_cycles++;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : stimulus
      req_type      item;
      rsp_type      no_rsp;
      mix_mode_type mode;
      int           segment_left;
      int           push_pct;
      int           dup_pct;
      int           roll;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      stack_count    = 0;
      deepest_seen   = 0;
      hold_requested = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      no_rsp       = '0;
      segment_left = 0;
      mode         = MIX_BALANCED;

      // Directed program, starting from an empty stack. Non-push rows carry
      // all-ones in value to show it is ignored.
      directed_rows = '{
         // every kind of underflow on an empty stack
         '{OP_ADD,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd0,  STATUS_UNDER}},
         '{OP_ABS,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd0,  STATUS_UNDER}},
         '{OP_DUP,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd0,  STATUS_UNDER}},
         '{OP_DIV,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd0,  STATUS_UNDER}},
         '{OP_PUSH, MOST_NEG,  8'd1,  1'b1, '{MOST_NEG,  5'd1,  STATUS_OK}},
         // binary op with a single entry
         '{OP_MOD,  MINUS_ONE, 8'd1,  1'b1, '{MOST_NEG,  5'd1,  STATUS_UNDER}},
         // abs of most-neg wraps to itself
         '{OP_ABS,  MINUS_ONE, 8'd1,  1'b1, '{MOST_NEG,  5'd1,  STATUS_OK}},
         '{OP_PUSH, MINUS_ONE, 8'd1,  1'b1, '{MINUS_ONE, 5'd2,  STATUS_OK}},
         // most-neg / -1 -> most-neg
         '{OP_DIV,  MINUS_ONE, 8'd1,  1'b1, '{MOST_NEG,  5'd1,  STATUS_OK}},
         '{OP_DUP,  MINUS_ONE, 8'd1,  1'b1, '{MOST_NEG,  5'd2,  STATUS_OK}},
         '{OP_PUSH, MINUS_ONE, 8'd1,  1'b1, '{MINUS_ONE, 5'd3,  STATUS_OK}},
         // most-neg mod -1 -> 0
         '{OP_MOD,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd2,  STATUS_OK}},
         '{OP_PUSH, 32'd0,     8'd1,  1'b1, '{32'd0,     5'd3,  STATUS_OK}},
         // divide by zero, both flavors, stack kept
         '{OP_DIV,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd3,  STATUS_DIVZ}},
         '{OP_MOD,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd3,  STATUS_DIVZ}},
         '{OP_SUB,  MINUS_ONE, 8'd1,  1'b1, '{32'd0,     5'd2,  STATUS_OK}},
         '{OP_ADD,  MINUS_ONE, 8'd1,  1'b1, '{MOST_NEG,  5'd1,  STATUS_OK}},
         '{OP_PUSH, MOST_POS,  8'd1,  1'b1, '{MOST_POS,  5'd2,  STATUS_OK}},
         '{OP_MUL,  MINUS_ONE, 8'd1,  1'b0, no_rsp},
         // remainder follows the dividend's sign
         '{OP_PUSH, 32'hFFFF_FFF9, 8'd1, 1'b0, no_rsp},
         '{OP_PUSH, 32'd2,     8'd1,  1'b0, no_rsp},
         '{OP_MOD,  MINUS_ONE, 8'd1,  1'b0, no_rsp},
         // fill to the brim, then overflow on push and on dup
         '{OP_PUSH, FILL_WORD, 8'd14, 1'b0, no_rsp},
         '{OP_PUSH, 32'd1,     8'd1,  1'b1, '{FILL_WORD, 5'd16, STATUS_OVER}},
         '{OP_DUP,  MINUS_ONE, 8'd1,  1'b1, '{FILL_WORD, 5'd16, STATUS_OVER}},
         '{OP_SUB,  MINUS_ONE, 8'd1,  1'b0, no_rsp}
      };

      sender_idle_pct = 21;
      rsp_idle_pct    = 74;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            item.op    = directed_rows[r].op;
            item.value = directed_rows[r].value;
            send_op(item, directed_rows[r].has_known, directed_rows[r].known_rsp);
         end
      end

      // Random programs in short segments, each leaning toward growing,
      // shrinking or holding the stack so overflow and underflow both recur.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            drain_results();
            sender_idle_pct = 74;
            rsp_idle_pct    = 21;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            drain_results();
            sender_idle_pct = 0;
            rsp_idle_pct    = 0;
         end
         if (n == 5 * RANDOM_ITEMS / 6) hold_requested++;

         if (segment_left == 0) begin
            mode         = mix_mode_type'($urandom_range(2));
            segment_left = $urandom_range(10, 40);
         end
         segment_left--;

         case (mode)
            MIX_FILL:  begin push_pct = 55; dup_pct = 20; end
            MIX_DRAIN: begin push_pct = 10; dup_pct = 5;  end
            default:   begin push_pct = 35; dup_pct = 8;  end
         endcase
         roll = $urandom_range(99);
         if (roll < push_pct) item.op = OP_PUSH;
         else if (roll < push_pct + dup_pct) item.op = OP_DUP;
         else item.op = OP_W'($urandom_range(OP_ADD, OP_ABS));

         // small values keep div/mod meaningful and make zero divisors common
         case ($urandom_range(9))
            0:       item.value = MOST_NEG;
            1:       item.value = MOST_POS;
            2:       item.value = '0;
            3:       item.value = MINUS_ONE;
            4, 5, 6: item.value = DATA_W'($urandom_range(20)) - DATA_W'(10);
            default: item.value = $urandom();
         endcase
         send_op(item, 1'b0, no_rsp);
      end

      drain_results();

      $display("ops %0d: push %0d add %0d sub %0d mul %0d div %0d mod %0d abs %0d dup %0d",
               op_seen.sum(), op_seen[OP_PUSH], op_seen[OP_ADD], op_seen[OP_SUB],
               op_seen[OP_MUL], op_seen[OP_DIV], op_seen[OP_MOD], op_seen[OP_ABS],
               op_seen[OP_DUP]);
      $display("results %0d (ok %0d under %0d over %0d divz %0d) depth %0d stalled %0d",
               results_checked, status_seen[STATUS_OK], status_seen[STATUS_UNDER],
               status_seen[STATUS_OVER], status_seen[STATUS_DIVZ], deepest_seen,
               backpressure_cycles);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
